FILE: rtl/core/ata_pkg.sv
// Shared types, constants and the arctangent table for the tilt angle unit.
// Used by the square root cells, the CORDIC cells and the top level.
package ata_pkg;

   localparam int SQRT_STAGES   = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int MAX_STAGES    = 24;
   localparam int SQ_IDX_W      = $clog2(SQRT_STAGES);
   localparam int CO_IDX_W      = $clog2(MAX_STAGES);
   localparam int LANE_W        = 40;
   localparam int ACC_W         = 32;
   localparam int PRESCALE_SH   = 20;

   localparam logic signed [ACC_W-1:0] ANG_HALF_PI = 32'sd26353589;
   localparam logic signed [16:0]      PI_Q13      = 17'sd25736;
   localparam logic [7:0]              FLOOR_RESET = 8'd3;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [31:0]        xx;
      logic [15:0]        m;
   } side_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] n;
      logic [31:0] res;
      side_type    side;
   } sqrt_stage_type;

   typedef struct packed {
      logic signed [LANE_W-1:0] x;
      logic signed [LANE_W-1:0] y;
      logic signed [ACC_W-1:0]  acc;
   } lane_type;

   typedef struct packed {
      logic     valid;
      lane_type pitch;
      lane_type roll;
      side_type side;
   } cordic_stage_type;

   function automatic logic signed [ACC_W-1:0] atan_entry(input logic [CO_IDX_W-1:0] idx);
      logic signed [ACC_W-1:0] v;
      case (idx)
         5'd0: v = 32'sd13176795;
         5'd1: v = 32'sd7778716;
         5'd2: v = 32'sd4110060;
         5'd3: v = 32'sd2086331;
         5'd4: v = 32'sd1047214;
         5'd5: v = 32'sd524117;
         5'd6: v = 32'sd262123;
         5'd7: v = 32'sd131069;
         5'd8: v = 32'sd65536;
         5'd9: v = 32'sd32768;
         5'd10: v = 32'sd16384;
         5'd11: v = 32'sd8192;
         5'd12: v = 32'sd4096;
         5'd13: v = 32'sd2048;
         5'd14: v = 32'sd1024;
         5'd15: v = 32'sd512;
         5'd16: v = 32'sd256;
         5'd17: v = 32'sd128;
         5'd18: v = 32'sd64;
         5'd19: v = 32'sd32;
         5'd20: v = 32'sd16;
         5'd21: v = 32'sd8;
         5'd22: v = 32'sd4;
         5'd23: v = 32'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/ata_sqrt_cell.sv
// One digit step of the pipelined integer square root, with its sideband.
// Depends on ata_pkg.
module ata_sqrt_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic [ata_pkg::SQ_IDX_W-1:0]         idx,
   input  ata_pkg::sqrt_stage_type              stage_in,
   output ata_pkg::sqrt_stage_type              stage_out
);

   ata_pkg::sqrt_stage_type stage_ff, stage_in_w;
   logic [31:0] bit_w;
   logic [31:0] trial;

   always_comb begin
      bit_w = 32'd1 << (5'd30 - {idx, 1'b0});
      trial = stage_in.res + bit_w;
      stage_in_w = stage_in;
      if (stage_in.n >= trial) begin
         stage_in_w.n   = stage_in.n - trial;
         stage_in_w.res = (stage_in.res >> 1) + bit_w;
      end else begin
         stage_in_w.res = stage_in.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;

endmodule

FILE: rtl/core/ata_cordic_cell.sv
// One vectoring iteration of the pitch and roll CORDIC lanes, with sideband.
// Depends on ata_pkg.
module ata_cordic_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic [ata_pkg::CO_IDX_W-1:0]         idx,
   input  ata_pkg::cordic_stage_type            stage_in,
   output ata_pkg::cordic_stage_type            stage_out
);

   ata_pkg::cordic_stage_type stage_ff, stage_in_w;

   function automatic ata_pkg::lane_type rotate(input ata_pkg::lane_type l,
                                                input logic [ata_pkg::CO_IDX_W-1:0] i);
      ata_pkg::lane_type r;
      logic signed [ata_pkg::LANE_W-1:0] ys;
      logic signed [ata_pkg::LANE_W-1:0] xs;
      ys = l.y >>> i;
      xs = l.x >>> i;
      if (l.y > 0) begin
         r.x   = l.x + ys;
         r.y   = l.y - xs;
         r.acc = l.acc + ata_pkg::atan_entry(i);
      end else begin
         r.x   = l.x - ys;
         r.y   = l.y + xs;
         r.acc = l.acc - ata_pkg::atan_entry(i);
      end
      return r;
   endfunction

   always_comb begin
      stage_in_w       = stage_in;
      stage_in_w.pitch = rotate(stage_in.pitch, idx);
      stage_in_w.roll  = rotate(stage_in.roll, idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;

endmodule

FILE: rtl/core/accel_tilt_angles_unit.sv
// Stages: squares, a square root chain of 16 cells, the magnitude floor register,
// a second square root chain of 16 cells, operand setup, 16 CORDIC cells, output
// register. Throughput: one request per cycle; the whole chain advances whenever
// the output register is empty or being taken. Reset clears all valid flags and
// sets the floor register to 3; no clearing pass is needed.
module accel_tilt_angles_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_x, accel_y, accel_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // magnitude, pitch, roll
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SN = ata_pkg::SQRT_STAGES;
   localparam int CN = ata_pkg::CORDIC_STAGES;

   logic [7:0] floor_ff;
   logic [7:0] fl;
   logic       advance;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {24'd0, floor_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= ata_pkg::FLOOR_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0) begin
         floor_ff <= csr_pwdata[7:0];
      end
   end

   assign fl = (floor_ff == 8'd0) ? 8'd1 : floor_ff;
   assign advance = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Squares stage.
   logic               sq_valid_ff;
   ata_pkg::side_type  sq_side_ff;
   logic [31:0]        yy_ff, zz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_side_ff.x  <= req_tdata[15:0];
         sq_side_ff.y  <= req_tdata[31:16];
         sq_side_ff.z  <= req_tdata[47:32];
         sq_side_ff.xx <= 32'($signed(req_tdata[15:0]) * $signed(req_tdata[15:0]));
         sq_side_ff.m  <= 16'd0;
         yy_ff         <= 32'($signed(req_tdata[31:16]) * $signed(req_tdata[31:16]));
         zz_ff         <= 32'($signed(req_tdata[47:32]) * $signed(req_tdata[47:32]));
      end
   end

   // First square root chain: magnitude.
   ata_pkg::sqrt_stage_type sq1 [0:SN];

   always_comb begin
      sq1[0].valid = sq_valid_ff;
      sq1[0].n     = sq_side_ff.xx + yy_ff + zz_ff;
      sq1[0].res   = 32'd0;
      sq1[0].side  = sq_side_ff;
   end

   genvar k;
   generate
      for (k = 0; k < SN; k++) begin : g_sqrt1
         ata_sqrt_cell u_cell (
            .clock(clock), .reset(reset), .advance(advance),
            .idx(ata_pkg::SQ_IDX_W'(k)), .stage_in(sq1[k]), .stage_out(sq1[k+1])
         );
      end
   endgenerate

   // Floor and square of the magnitude.
   logic               mg_valid_ff;
   ata_pkg::side_type  mg_side_ff, mg_side_in;
   logic [31:0]        mm_ff;
   logic [15:0]        m_raw, m_fl;

   assign m_raw = sq1[SN].res[15:0];
   assign m_fl  = (m_raw < {8'd0, fl}) ? {8'd0, fl} : m_raw;

   always_comb begin
      mg_side_in   = sq1[SN].side;
      mg_side_in.m = m_fl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mg_valid_ff <= 1'b0;
      end else if (advance) begin
         mg_valid_ff <= sq1[SN].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mg_side_ff <= mg_side_in;
         mm_ff      <= m_fl * m_fl;
      end
   end

   // Second square root chain: cosine leg for pitch.
   ata_pkg::sqrt_stage_type sq2 [0:SN];

   always_comb begin
      sq2[0].valid = mg_valid_ff;
      sq2[0].n     = (mm_ff >= mg_side_ff.xx) ? mm_ff - mg_side_ff.xx : 32'd0;
      sq2[0].res   = 32'd0;
      sq2[0].side  = mg_side_ff;
   end

   generate
      for (k = 0; k < SN; k++) begin : g_sqrt2
         ata_sqrt_cell u_cell (
            .clock(clock), .reset(reset), .advance(advance),
            .idx(ata_pkg::SQ_IDX_W'(k)), .stage_in(sq2[k]), .stage_out(sq2[k+1])
         );
      end
   endgenerate

   // CORDIC operand setup with quadrant pre-rotation.
   ata_pkg::cordic_stage_type co [0:CN];
   ata_pkg::cordic_stage_type setup_ff, setup_in;
   logic [15:0]        c_leg;
   logic [16:0]        az;
   logic signed [15:0] zr;
   logic signed [ata_pkg::LANE_W-1:0] rx, ry;

   always_comb begin
      c_leg = sq2[SN].res[15:0];
      az    = sq2[SN].side.z[15] ? 17'(-$signed({sq2[SN].side.z[15], sq2[SN].side.z}))
                                 : {1'b0, sq2[SN].side.z};
      zr    = (az < {9'd0, fl}) ? $signed({8'd0, fl}) : sq2[SN].side.z;
      rx    = $signed({{4{zr[15]}}, zr, 20'd0});
      ry    = $signed({{4{sq2[SN].side.y[15]}}, sq2[SN].side.y, 20'd0});

      setup_in.valid     = sq2[SN].valid;
      setup_in.side      = sq2[SN].side;
      setup_in.pitch.x   = $signed({4'd0, c_leg, 20'd0});
      setup_in.pitch.y   = -$signed({{4{sq2[SN].side.x[15]}}, sq2[SN].side.x, 20'd0});
      setup_in.pitch.acc = '0;
      setup_in.roll.x    = rx;
      setup_in.roll.y    = ry;
      setup_in.roll.acc  = '0;
      if (rx < 0) begin
         if (ry >= 0) begin
            setup_in.roll.x   = ry;
            setup_in.roll.y   = -rx;
            setup_in.roll.acc = ata_pkg::ANG_HALF_PI;
         end else begin
            setup_in.roll.x   = -ry;
            setup_in.roll.y   = rx;
            setup_in.roll.acc = -ata_pkg::ANG_HALF_PI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff.valid <= 1'b0;
      end else if (advance) begin
         setup_ff <= setup_in;
      end
   end

   assign co[0] = setup_ff;

   generate
      for (k = 0; k < CN; k++) begin : g_cordic
         ata_cordic_cell u_cell (
            .clock(clock), .reset(reset), .advance(advance),
            .idx(ata_pkg::CO_IDX_W'(k)), .stage_in(co[k]), .stage_out(co[k+1])
         );
      end
   endgenerate

   // Rounding, clamping, pitch folding and output register.
   logic signed [20:0] pq_w, rq_w;
   logic signed [15:0] pq, rq;
   logic signed [16:0] pf;
   logic               rsp_valid_ff;
   logic [47:0]        rsp_data_ff;

   always_comb begin
      pq_w = 21'((co[CN].pitch.acc + 32'sd1024) >>> 11);
      rq_w = 21'((co[CN].roll.acc + 32'sd1024) >>> 11);
      pq = (pq_w > 21'sd32767) ? 16'sd32767 :
           (pq_w < -21'sd32768) ? -16'sd32768 : pq_w[15:0];
      rq = (rq_w > 21'sd32767) ? 16'sd32767 :
           (rq_w < -21'sd32768) ? -16'sd32768 : rq_w[15:0];
      pf = {pq[15], pq};
      if (co[CN].side.z[15] && pq > 0) begin
         pf = ata_pkg::PI_Q13 - {pq[15], pq};
      end else if (co[CN].side.z[15] && pq < 0) begin
         pf = -ata_pkg::PI_Q13 - {pq[15], pq};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= co[CN].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {rq, pf[15:0], co[CN].side.m};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
